@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the core top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OWBG_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OWBG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/owbg_pkg.sv @@
`default_nettype none
package owbg_pkg;

   localparam int unsigned RatioW = 10;
   localparam int unsigned QuotW  = 20;
   localparam int unsigned GainW  = 16;

   localparam logic [RatioW-1:0] GoldenRgReset = 10'd308;
   localparam logic [RatioW-1:0] GoldenBgReset = 10'd324;
   localparam logic [QuotW-1:0]  RatioScale    = 20'd1000;
   localparam logic [GainW-1:0]  UnityGain     = 16'h0400;
   localparam logic [GainW-1:0]  GainMax       = 16'hFFFF;

   localparam logic [7:0] Grp1Mask = 8'hC0;
   localparam logic [7:0] Grp1Val  = 8'h40;
   localparam logic [7:0] Grp2Mask = 8'h30;
   localparam logic [7:0] Grp2Val  = 8'h10;

   typedef enum logic [0:0] {
      REG_GOLDEN_RG = 1'b0,
      REG_GOLDEN_BG = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_GROUP   = 2'd1,
      ST_ZERO_RATIO = 2'd2
   } status_type;

   // sideband riding along the gain dividers
   typedef struct packed {
      status_type status;
      logic       sat_r;
      logic       sat_g;
      logic       sat_b;
   } gain_side_type;

endpackage
`default_nettype wire

@@ rtl/core/owbg_div_cell.sv @@
`default_nettype none
// One restoring-division step: shifts in the next dividend bit, subtracts the
// divisor if it fits and shifts the quotient bit in behind the dividend.
module owbg_div_cell #(
   parameter int unsigned DW = 10,
   parameter int unsigned QW = 20
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [DW-1:0] d_i,
   input  wire logic [DW-1:0] rem_i,
   input  wire logic [QW-1:0] dq_i,
   output logic      [DW-1:0] d_o,
   output logic      [DW-1:0] rem_o,
   output logic      [QW-1:0] dq_o
);

   logic [DW-1:0] d_ff, rem_ff, rem_in;
   logic [QW-1:0] dq_ff, dq_in;
   logic [DW:0]   trial, diff;
   logic          fits;

   always_comb begin
      trial  = {rem_i, dq_i[QW-1]};
      fits   = trial >= {1'b0, d_i};
      diff   = trial - {1'b0, d_i};
      rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
      dq_in  = {dq_i[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff   <= d_i;
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign d_o   = d_ff;
   assign rem_o = rem_ff;
   assign dq_o  = dq_ff;

endmodule
`default_nettype wire

@@ rtl/core/otp_white_balance_gain.sv @@
// Stages from accepted item to result: 20 ratio-divider cells, one base-select
//   stage, 16 gain-divider cells and one output register.
// Throughput: one item per cycle; the whole pipe advances together and halts
//   only while a finished result is stalled at the output.
// Reset: synchronous, active high; clears the valid bits and loads the golden
//   ratios with 308 and 324.
`default_nettype none
`include "assert_macros.svh"
module otp_white_balance_gain (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [9:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_info_flag,
   input  wire logic [7:0]  req_rg_high,
   input  wire logic [7:0]  req_bg_high,
   input  wire logic [7:0]  req_ratio_low_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_red_gain,
   output logic [15:0]      rsp_green_gain,
   output logic [15:0]      rsp_blue_gain,
   output logic             rsp_red_apply,
   output logic             rsp_green_apply,
   output logic             rsp_blue_apply,
   output logic [1:0]       rsp_status
);

   localparam int unsigned RW = owbg_pkg::RatioW;
   localparam int unsigned QW = owbg_pkg::QuotW;
   localparam int unsigned GW = owbg_pkg::GainW;
   localparam int unsigned AN = QW;     // ratio divider cells
   localparam int unsigned BN = GW;     // gain divider cells
   localparam int unsigned FracW = 10;  // 1024 scale

   logic [RW-1:0] golden_rg_ff, golden_bg_ff;
   logic          en;

   always_ff @(posedge clock) begin
      if (reset) begin
         golden_rg_ff <= owbg_pkg::GoldenRgReset;
         golden_bg_ff <= owbg_pkg::GoldenBgReset;
      end else if (csr_we) begin
         case (owbg_pkg::reg_index_type'(csr_index))
            owbg_pkg::REG_GOLDEN_RG: golden_rg_ff <= csr_wdata;
            owbg_pkg::REG_GOLDEN_BG: golden_bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- ratio dividers ----------------
   logic [RW-1:0] ra_d [0:AN], ra_rem [0:AN], ba_d [0:AN], ba_rem [0:AN];
   logic [QW-1:0] ra_dq [0:AN], ba_dq [0:AN];
   owbg_pkg::status_type sa [0:AN];
   logic                 va [0:AN];
   logic                 grp_ok;

   assign grp_ok =
      ((req_info_flag & owbg_pkg::Grp1Mask) == owbg_pkg::Grp1Val) ||
      ((req_info_flag & owbg_pkg::Grp2Mask) == owbg_pkg::Grp2Val);
   assign ra_d[0]   = {req_rg_high, req_ratio_low_bits[7:6]};
   assign ba_d[0]   = {req_bg_high, req_ratio_low_bits[5:4]};
   assign ra_rem[0] = '0;
   assign ba_rem[0] = '0;
   assign ra_dq[0]  = {{(QW-RW){1'b0}}, golden_rg_ff} * owbg_pkg::RatioScale;
   assign ba_dq[0]  = {{(QW-RW){1'b0}}, golden_bg_ff} * owbg_pkg::RatioScale;
   assign va[0]     = req_valid;
   assign sa[0]     = !grp_ok ? owbg_pkg::ST_NO_GROUP :
                      (ra_d[0] == '0 || ba_d[0] == '0) ? owbg_pkg::ST_ZERO_RATIO :
                      owbg_pkg::ST_OK;

   for (genvar i = 0; i < AN; i++) begin : g_ratio
      logic                 va_ff;
      owbg_pkg::status_type sa_ff;
      owbg_div_cell #(.DW(RW), .QW(QW)) u_rg (
         .clock, .enable(en), .d_i(ra_d[i]), .rem_i(ra_rem[i]), .dq_i(ra_dq[i]),
         .d_o(ra_d[i+1]), .rem_o(ra_rem[i+1]), .dq_o(ra_dq[i+1]));
      owbg_div_cell #(.DW(RW), .QW(QW)) u_bg (
         .clock, .enable(en), .d_i(ba_d[i]), .rem_i(ba_rem[i]), .dq_i(ba_dq[i]),
         .d_o(ba_d[i+1]), .rem_o(ba_rem[i+1]), .dq_o(ba_dq[i+1]));
      always_ff @(posedge clock) begin
         if (reset) va_ff <= 1'b0;
         else if (en) va_ff <= va[i];
      end
      always_ff @(posedge clock) begin
         if (en) sa_ff <= sa[i];
      end
      assign va[i+1] = va_ff;
      assign sa[i+1] = sa_ff;
   end

   // ---------------- base select ----------------
   logic [QW-1:0] rq, bq, base_in, base_ff, rq_ff, bq_ff;
   logic          mid_valid_ff;
   owbg_pkg::gain_side_type mid_side_ff, mid_side_in;

   assign rq = ra_dq[AN];
   assign bq = ba_dq[AN];

   always_comb begin
      if (rq < owbg_pkg::RatioScale || bq < owbg_pkg::RatioScale)
         base_in = (rq < bq) ? rq : bq;
      else
         base_in = owbg_pkg::RatioScale;
      // gain saturates when q*1024/base >= 65536, i.e. q >= 64*base
      mid_side_in.status = sa[AN];
      mid_side_in.sat_r  = {{(GW-FracW){1'b0}}, rq} >= {base_in, {(GW-FracW){1'b0}}};
      mid_side_in.sat_g  = {{(GW-FracW){1'b0}}, owbg_pkg::RatioScale}
                           >= {base_in, {(GW-FracW){1'b0}}};
      mid_side_in.sat_b  = {{(GW-FracW){1'b0}}, bq} >= {base_in, {(GW-FracW){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) mid_valid_ff <= 1'b0;
      else if (en) mid_valid_ff <= va[AN];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff     <= base_in;
         rq_ff       <= rq;
         bq_ff       <= bq;
         mid_side_ff <= mid_side_in;
      end
   end

   // ---------------- gain dividers ----------------
   localparam int unsigned Sh = GW - FracW;
   logic [QW-1:0] gd [3][0:BN], grem [3][0:BN];
   logic [GW-1:0] gdq [3][0:BN];
   logic [QW-1:0] gq [3];
   owbg_pkg::gain_side_type sb [0:BN];
   logic                    vb [0:BN];

   assign gq[0] = rq_ff;
   assign gq[1] = owbg_pkg::RatioScale;
   assign gq[2] = bq_ff;
   assign sb[0] = mid_side_ff;
   assign vb[0] = mid_valid_ff;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      // dividend q<<10: its top bits seed the remainder, low bits enter the shifter
      assign gd[l][0]   = base_ff;
      assign grem[l][0] = {{Sh{1'b0}}, gq[l][QW-1:Sh]};
      assign gdq[l][0]  = {gq[l][Sh-1:0], {FracW{1'b0}}};
      for (genvar i = 0; i < BN; i++) begin : g_cell
         owbg_div_cell #(.DW(QW), .QW(GW)) u_cell (
            .clock, .enable(en),
            .d_i(gd[l][i]), .rem_i(grem[l][i]), .dq_i(gdq[l][i]),
            .d_o(gd[l][i+1]), .rem_o(grem[l][i+1]), .dq_o(gdq[l][i+1]));
      end
   end

   for (genvar i = 0; i < BN; i++) begin : g_gside
      logic                    vb_ff;
      owbg_pkg::gain_side_type sb_ff;
      always_ff @(posedge clock) begin
         if (reset) vb_ff <= 1'b0;
         else if (en) vb_ff <= vb[i];
      end
      always_ff @(posedge clock) begin
         if (en) sb_ff <= sb[i];
      end
      assign vb[i+1] = vb_ff;
      assign sb[i+1] = sb_ff;
   end

   // ---------------- output register ----------------
   logic [GW-1:0] r_in, g_in, b_in, r_ff, g_ff, b_ff;
   logic          ok, out_valid_ff;
   logic [1:0]    status_ff;
   logic          ra_ff, ga_ff, ba_ff;

   always_comb begin
      ok   = sb[BN].status == owbg_pkg::ST_OK;
      r_in = !ok ? '0 : sb[BN].sat_r ? owbg_pkg::GainMax : gdq[0][BN];
      g_in = !ok ? '0 : sb[BN].sat_g ? owbg_pkg::GainMax : gdq[1][BN];
      b_in = !ok ? '0 : sb[BN].sat_b ? owbg_pkg::GainMax : gdq[2][BN];
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= vb[BN];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff      <= r_in;
         g_ff      <= g_in;
         b_ff      <= b_in;
         ra_ff     <= r_in > owbg_pkg::UnityGain;
         ga_ff     <= g_in > owbg_pkg::UnityGain;
         ba_ff     <= b_in > owbg_pkg::UnityGain;
         status_ff <= sb[BN].status;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_red_gain    = r_ff;
   assign rsp_green_gain  = g_ff;
   assign rsp_blue_gain   = b_ff;
   assign rsp_red_apply   = ra_ff;
   assign rsp_green_apply = ga_ff;
   assign rsp_blue_apply  = ba_ff;
   assign rsp_status      = status_ff;

   `OWBG_ASSERT_IMPLY(a_err_zero, clock, reset,
      rsp_valid && rsp_status != owbg_pkg::ST_OK,
      rsp_red_gain == '0 && rsp_green_gain == '0 && rsp_blue_gain == '0,
      "error item carries nonzero gain")
   `OWBG_ASSERT_IMPLY(a_apply, clock, reset, rsp_valid,
      rsp_red_apply == (rsp_red_gain > owbg_pkg::UnityGain) &&
      rsp_blue_apply == (rsp_blue_gain > owbg_pkg::UnityGain),
      "apply flag disagrees with gain")
   `OWBG_ASSERT_IMPLY(a_status, clock, reset, rsp_valid,
      rsp_status != 2'd3, "undefined status code")
   `OWBG_ASSERT_NEXT(a_hold_mid, clock, reset, !en && mid_valid_ff,
      mid_valid_ff, "item lost in halted pipe")

endmodule
`default_nettype wire
